>>> rtl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

    // Command codes carried on the mode input
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_SLEEP = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLP_RD,
        ST_SLP_WR,
        ST_SLC_RD,
        ST_SLC_WR,
        ST_SRCH,
        ST_ADD_SCAN,
        ST_SLEEP_WR,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;       // capture the input beat, clear result flags
        logic idx_clear;   // slot walk counter to zero
        logic idx_inc;     // slot walk counter up by one
        logic sleep_rd;    // read sleep counter at the walk index
        logic sleep_wb;    // write back decremented sleep counter, update awake bit
        logic start_slot0; // start slot 0 from the no-task state
        logic slice_rd;    // read slice counter and reload of the running slot
        logic slice_wb;    // write back slice counter, seed the search candidate
        logic srch_step;   // candidate to the next slot
        logic srch_take;   // candidate becomes the running slot
        logic add_write;   // fill the slot at the walk index
        logic add_full;    // flag a full table
        logic sleep_write; // put the running task to sleep
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic idx_last;    // walk index at the last slot
        logic idx_free;    // slot at walk index is free
        logic run_none;    // nothing running
        logic present0;    // slot 0 holds a task
        logic slice_zero;  // running slice ends on this tick
        logic cand_is_old; // search wrapped back to the running slot
        logic cand_awake;  // candidate is present and awake
    } status_t;

endpackage

>>> rtl/round_robin_task_scheduler_core.sv
`timescale 1ns / 1ps
// Round-robin task scheduler with per-slot time slices and sleep counters.
// Command channel: a beat (mode, slice_length, sleep_ticks) is taken at a
// rising edge with start high and busy low. mode selects tick, add or sleep.
// Result channel: done is high for one cycle with running_task, switched,
// added_slot and table_full valid; the receiver cannot stall, so the beat
// is taken in that cycle and busy falls on the next edge.
// Command sequences, with N = TASK_SLOTS:
//   tick  : the sleep counter sweep reads, then writes back, each of the
//           N slots in turn; then the running slot's slice counter is
//           read and written back, and if the slice ends, the successor
//           search checks one slot per cycle.
//   add   : the free-slot scan checks one slot per cycle.
//   sleep : writes the running task's counters; unused codes go to done.
// One command is in flight at a time; the next start is taken only once
// the block is idle again after done.
// Reset (rst_n low, asynchronous) empties the table and sets running_task
// to N, meaning none. Counter memories need no clearing: a slot's entries
// are written when the slot is added and used only once it is present.
module round_robin_task_scheduler_core
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] slice_length,
    input  logic [31:0] sleep_ticks,
    output logic        done,
    output logic [3:0]  running_task,
    output logic        switched,
    output logic [2:0]  added_slot,
    output logic        table_full
);

    cmd_t    cmd;
    status_t status;

    rrts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rrts_datapath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .slice_length (slice_length),
        .sleep_ticks  (sleep_ticks),
        .status       (status),
        .running_task (running_task),
        .switched     (switched),
        .added_slot   (added_slot),
        .table_full   (table_full)
    );

endmodule

>>> rtl/rrts_ctrl.sv
`timescale 1ns / 1ps

module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  status_t    status,
    output cmd_t       cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch     = 1'b1;
                    cmd.idx_clear = 1'b1;
                    case (mode)
                        MODE_TICK:  state_next = ST_SLP_RD;
                        MODE_ADD:   state_next = ST_ADD_SCAN;
                        MODE_SLEEP: state_next = ST_SLEEP_WR;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_SLP_RD:
            begin
                cmd.sleep_rd = 1'b1;
                state_next   = ST_SLP_WR;
            end
            ST_SLP_WR:
            begin
                cmd.sleep_wb = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clear = 1'b1;
                    if (status.run_none)
                    begin
                        cmd.start_slot0 = status.present0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SLC_RD;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SLP_RD;
                end
            end
            ST_SLC_RD:
            begin
                cmd.slice_rd = 1'b1;
                state_next   = ST_SLC_WR;
            end
            ST_SLC_WR:
            begin
                cmd.slice_wb = 1'b1;
                state_next   = status.slice_zero ? ST_SRCH : ST_DONE;
            end
            ST_SRCH:
            begin
                if (status.cand_is_old)
                begin
                    state_next = ST_DONE;
                end
                else if (status.cand_awake)
                begin
                    cmd.srch_take = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            ST_ADD_SCAN:
            begin
                if (status.idx_free)
                begin
                    cmd.add_write = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (status.idx_last)
                begin
                    cmd.add_full = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_SLEEP_WR:
            begin
                cmd.sleep_write = !status.run_none;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rrts_datapath.sv
`timescale 1ns / 1ps

module rrts_datapath
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [31:0] slice_length,
    input  logic [31:0] sleep_ticks,
    output status_t     status,
    output logic [3:0]  running_task,
    output logic        switched,
    output logic [2:0]  added_slot,
    output logic        table_full
);

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int RW = $clog2(TASK_SLOTS + 1);
    localparam logic [RW-1:0] RUN_NONE = RW'(TASK_SLOTS);
    localparam logic [SW-1:0] IDX_LAST = SW'(TASK_SLOTS - 1);

    // Per-slot counters held in memories
    logic [31:0] sleep_left_reg   [TASK_SLOTS];
    logic [31:0] slice_left_reg   [TASK_SLOTS];
    logic [31:0] slice_reload_reg [TASK_SLOTS];
    logic [31:0] sleep_rdata_reg;
    logic [31:0] slice_rdata_reg;
    logic [31:0] reload_rdata_reg;

    logic [TASK_SLOTS-1:0] present_reg;
    logic [TASK_SLOTS-1:0] awake_reg;
    logic [RW-1:0]         running_reg;
    logic [SW-1:0]         idx_reg;
    logic [SW-1:0]         cand_reg;
    logic [31:0]           slice_length_reg;
    logic [31:0]           sleep_ticks_reg;
    logic                  switched_reg;
    logic [SW-1:0]         added_reg;
    logic                  full_reg;

    logic [SW-1:0] run_idx;
    logic [SW-1:0] run_next_idx;
    logic [SW-1:0] cand_next;
    logic [31:0]   sleep_dec;
    logic [31:0]   slice_dec;
    logic          sleep_we;
    logic [SW-1:0] sleep_waddr;
    logic [31:0]   sleep_wdata;
    logic          slice_we;
    logic [SW-1:0] slice_waddr;
    logic [31:0]   slice_wdata;
    logic [RW+3:0] run_ext;
    logic [SW+2:0] added_ext;

    assign run_idx      = running_reg[SW-1:0];
    assign run_next_idx = (run_idx == IDX_LAST) ? '0 : run_idx + 1'b1;
    assign cand_next    = (cand_reg == IDX_LAST) ? '0 : cand_reg + 1'b1;
    assign sleep_dec    = (sleep_rdata_reg != 32'd0) ? sleep_rdata_reg - 32'd1 : 32'd0;
    assign slice_dec    = slice_rdata_reg - 32'd1;

    // Select sleep counter write port
    always_comb
    begin
        sleep_we    = (cmd.sleep_wb && present_reg[idx_reg]) || cmd.add_write
                      || cmd.sleep_write;
        sleep_waddr = cmd.sleep_write ? run_idx : idx_reg;
        if (cmd.add_write)
        begin
            sleep_wdata = 32'd0;
        end
        else if (cmd.sleep_write)
        begin
            sleep_wdata = sleep_ticks_reg;
        end
        else
        begin
            sleep_wdata = sleep_dec;
        end
    end

    // Select slice counter write port
    always_comb
    begin
        slice_we    = cmd.slice_wb || cmd.add_write || cmd.sleep_write;
        slice_waddr = cmd.add_write ? idx_reg : run_idx;
        if (cmd.add_write)
        begin
            slice_wdata = slice_length_reg;
        end
        else if (cmd.sleep_write)
        begin
            slice_wdata = 32'd1;
        end
        else if (slice_dec == 32'd0)
        begin
            slice_wdata = reload_rdata_reg;
        end
        else
        begin
            slice_wdata = slice_dec;
        end
    end

    // Sleep counter memory
    always_ff @(posedge clk)
    begin
        if (sleep_we)
        begin
            sleep_left_reg[sleep_waddr] <= sleep_wdata;
        end
        if (cmd.sleep_rd)
        begin
            sleep_rdata_reg <= sleep_left_reg[idx_reg];
        end
    end

    // Slice counter memory
    always_ff @(posedge clk)
    begin
        if (slice_we)
        begin
            slice_left_reg[slice_waddr] <= slice_wdata;
        end
        if (cmd.slice_rd)
        begin
            slice_rdata_reg <= slice_left_reg[run_idx];
        end
    end

    // Slice reload memory
    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
        begin
            slice_reload_reg[idx_reg] <= slice_length_reg;
        end
        if (cmd.slice_rd)
        begin
            reload_rdata_reg <= slice_reload_reg[run_idx];
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            slice_length_reg <= slice_length;
            sleep_ticks_reg  <= sleep_ticks;
        end
    end

    // Slot flags, walk counters and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= '0;
            awake_reg    <= '0;
            running_reg  <= RUN_NONE;
            idx_reg      <= '0;
            cand_reg     <= '0;
            switched_reg <= 1'b0;
            added_reg    <= '0;
            full_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                switched_reg <= 1'b0;
                added_reg    <= '0;
                full_reg     <= 1'b0;
            end
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.sleep_wb)
            begin
                awake_reg[idx_reg] <= present_reg[idx_reg] && (sleep_dec == 32'd0);
            end
            if (cmd.start_slot0)
            begin
                running_reg  <= '0;
                switched_reg <= 1'b1;
            end
            if (cmd.slice_wb)
            begin
                cand_reg <= run_next_idx;
            end
            else if (cmd.srch_step)
            begin
                cand_reg <= cand_next;
            end
            if (cmd.srch_take)
            begin
                running_reg  <= RW'(cand_reg);
                switched_reg <= 1'b1;
            end
            if (cmd.add_write)
            begin
                present_reg[idx_reg] <= 1'b1;
                added_reg            <= idx_reg;
            end
            if (cmd.add_full)
            begin
                full_reg <= 1'b1;
            end
        end
    end

    // Drive status
    always_comb
    begin
        status.idx_last    = (idx_reg == IDX_LAST);
        status.idx_free    = !present_reg[idx_reg];
        status.run_none    = (running_reg == RUN_NONE);
        status.present0    = present_reg[0];
        status.slice_zero  = (slice_dec == 32'd0);
        status.cand_is_old = (cand_reg == run_idx);
        status.cand_awake  = awake_reg[cand_reg];
    end

    // Fit results to the port widths
    assign run_ext      = {4'd0, running_reg};
    assign added_ext    = {3'd0, added_reg};
    assign running_task = run_ext[3:0];
    assign added_slot   = added_ext[2:0];
    assign switched     = switched_reg;
    assign table_full   = full_reg;

endmodule

>>> rtl/rrts_checker.sv
`timescale 1ns / 1ps

module rrts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       switched,
    input logic [2:0] added_slot,
    input logic       table_full
);

    // Result beat only while a command is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // Strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // Accepted command keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // A full table reports no slot and no switch
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> (added_slot == 3'd0 && !switched))
        else $error("full result carries slot or switch");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .switched   (switched),
    .added_slot (added_slot),
    .table_full (table_full)
);
